// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the odometry RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ODO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition on one edge is followed by another on the next edge.
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/odo_pkg.sv =====
// Shared widths, constants, types and the arctangent table of the odometry block.
`default_nettype none

package odo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int ATAN_DEPTH   = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

  localparam int ROT_W    = 32;
  localparam int HEAD_W   = 16;
  localparam int CIRC_W   = 16;
  localparam int CIRC_FRAC = 8;
  localparam int TRAVEL_W = 40;
  localparam int STEP_W   = 40;
  localparam int POSE_W   = 48;

  // CORDIC datapath: Q2.30 vector with headroom, angle with two guard bits.
  localparam int CW       = 33;
  localparam int ZW       = ANGLE_BITS + 2;
  localparam int TRIG_SHIFT = 8;
  localparam int TRIG_W   = CW - TRIG_SHIFT;
  localparam int TRIG_FRAC = 22;

  // Shared multiplier and the split of the step into two partial products.
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 27;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int LO_W     = 20;
  localparam int ACC_W    = 66;
  localparam int INC_W    = ACC_W - TRIG_FRAC;

  localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(3217);
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic signed [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic signed [POSE_W-1:0] POSE_MAX = {1'b0, {(POSE_W-1){1'b1}}};
  localparam logic signed [POSE_W-1:0] POSE_MIN = {1'b1, {(POSE_W-1){1'b0}}};

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS32 [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                     valid;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [CNT_W-1:0] idx);
    logic [31:0] t;
    t = ATAN_TURNS32[ATAN_IDX_W'(idx)];
    return $signed(ZW'(t >> (32 - ANGLE_BITS)));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/odo_if.sv =====
// Valid/ready channel interfaces for odometry requests and results.
`default_nettype none

interface odo_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odo_pkg::ROT_W-1:0]     right_rotations;
  logic signed [odo_pkg::ROT_W-1:0]     left_rotations;
  logic        [odo_pkg::HEAD_W-1:0]    heading;

  modport source (output valid, right_rotations, left_rotations, heading, input ready);
  modport sink (input valid, right_rotations, left_rotations, heading, output ready);
endinterface

interface odo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odo_pkg::POSE_W-1:0]    x_position;
  logic signed [odo_pkg::POSE_W-1:0]    y_position;
  logic signed [odo_pkg::STEP_W-1:0]    step_distance;

  modport source (output valid, x_position, y_position, step_distance, input ready);
  modport sink (input valid, x_position, y_position, step_distance, output ready);
endinterface

`default_nettype wire

// ===== rtl/odo_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module odo_mul (
  input  logic                                clk,
  input  logic signed [odo_pkg::MUL_A_W-1:0]  mul_a,
  input  logic signed [odo_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [odo_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

// ===== rtl/odo_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine of the heading.
`default_nettype none
`include "assert_macros.svh"

module odo_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [odo_pkg::HEAD_W-1:0]    heading,
  output odo_pkg::trig_t                trig
);

  logic                              busy_r;
  logic                              fin_r;
  logic                              valid_r;
  logic [odo_pkg::CNT_W-1:0]         it_r;
  logic                              flip_r;
  logic signed [odo_pkg::CW-1:0]     x_r;
  logic signed [odo_pkg::CW-1:0]     y_r;
  logic signed [odo_pkg::ZW-1:0]     z_r;
  logic signed [odo_pkg::TRIG_W-1:0] sin_r;
  logic signed [odo_pkg::TRIG_W-1:0] cos_r;

  logic [odo_pkg::ANGLE_BITS-1:0]    ang;
  logic [odo_pkg::ANGLE_BITS-1:0]    ang_fold;
  logic                              quad_flip;
  logic signed [odo_pkg::CW-1:0]     dx;
  logic signed [odo_pkg::CW-1:0]     dy;
  logic signed [odo_pkg::ZW-1:0]     da;
  logic signed [odo_pkg::CW-1:0]     x_nxt;
  logic signed [odo_pkg::CW-1:0]     y_nxt;
  logic signed [odo_pkg::ZW-1:0]     z_nxt;
  logic signed [odo_pkg::CW-1:0]     x_out;
  logic signed [odo_pkg::CW-1:0]     y_out;

  // Headings in the second and third quadrants are turned by half a turn,
  // which flips the top bit; the result is negated at the end.
  assign ang       = heading[odo_pkg::HEAD_W-1 -: odo_pkg::ANGLE_BITS];
  assign quad_flip = ang[odo_pkg::ANGLE_BITS-1] ^ ang[odo_pkg::ANGLE_BITS-2];
  assign ang_fold  = {ang[odo_pkg::ANGLE_BITS-1] ^ quad_flip, ang[odo_pkg::ANGLE_BITS-2:0]};

  always_comb begin
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    da = odo_pkg::atan_step(it_r);
    if (!z_r[odo_pkg::ZW-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - da;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + da;
    end
    x_out = flip_r ? -x_r : x_r;
    y_out = flip_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      valid_r <= 1'b0;
      it_r    <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        valid_r <= 1'b0;
        it_r    <= '0;
      end else if (busy_r) begin
        it_r <= odo_pkg::CNT_W'(it_r + 1'b1);
        if (it_r == odo_pkg::CNT_W'(odo_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= odo_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= odo_pkg::ZW'($signed(ang_fold));
      flip_r <= quad_flip;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    if (fin_r) begin
      sin_r <= y_out[odo_pkg::CW-1:odo_pkg::TRIG_SHIFT];
      cos_r <= x_out[odo_pkg::CW-1:odo_pkg::TRIG_SHIFT];
    end
  end

  assign trig.valid = valid_r;
  assign trig.sin_v = sin_r;
  assign trig.cos_v = cos_r;

  `ODO_ASSERT(a_start_when_free, start |-> (!busy_r && !fin_r), "CORDIC restarted while running")

endmodule

`default_nettype wire

// ===== rtl/differential_drive_odometry_top.sv =====
// Top level of the differential-drive odometry block: sequencer and datapath.
// A new request is accepted only in the idle state, once the previous result has been
// loaded into the output register; the CORDIC iterations set the time per request.
// The multiplier is shared by both wheel scalings and the four pose partial products.
// Synchronous active-low reset clears pose, old travels and control; circumference
// returns to 3217 (about four times pi, with eight fraction bits). No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module differential_drive_odometry_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [odo_pkg::CIRC_W-1:0]     cfg_wdata,
  odo_in_if.sink                         in_ch,
  odo_out_if.source                      out_ch
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MR    = 12'b000000000010,
    S_ML    = 12'b000000000100,
    S_LT    = 12'b000000001000,
    S_STEP  = 12'b000000010000,
    S_CORD  = 12'b000000100000,
    S_XL    = 12'b000001000000,
    S_XH    = 12'b000010000000,
    S_YL    = 12'b000100000000,
    S_YH    = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [odo_pkg::CIRC_W-1:0]          circ_r;
  logic signed [odo_pkg::ROT_W-1:0]    rr_r;
  logic signed [odo_pkg::ROT_W-1:0]    lr_r;
  logic signed [odo_pkg::TRAVEL_W-1:0] rt_r;
  logic signed [odo_pkg::TRAVEL_W-1:0] lt_r;
  logic signed [odo_pkg::TRAVEL_W-1:0] last_rt_r;
  logic signed [odo_pkg::TRAVEL_W-1:0] last_lt_r;
  logic signed [odo_pkg::TRAVEL_W:0]   dr_r;
  logic signed [odo_pkg::TRAVEL_W:0]   dl_r;
  logic signed [odo_pkg::STEP_W-1:0]   step_r;
  logic signed [odo_pkg::ACC_W-1:0]    acc_r;
  logic signed [odo_pkg::POSE_W-1:0]   pose_x_r;
  logic signed [odo_pkg::POSE_W-1:0]   pose_y_r;
  logic                                out_valid_r;
  logic signed [odo_pkg::POSE_W-1:0]   out_x_r;
  logic signed [odo_pkg::POSE_W-1:0]   out_y_r;
  logic signed [odo_pkg::STEP_W-1:0]   out_step_r;

  logic                                in_acc;
  logic                                out_load;
  odo_pkg::trig_t                      trig;
  logic signed [odo_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [odo_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [odo_pkg::PROD_W-1:0]   prod_r;
  logic signed [odo_pkg::MUL_A_W-1:0]  step_lo_a;
  logic signed [odo_pkg::MUL_A_W-1:0]  step_hi_a;
  logic signed [odo_pkg::MUL_B_W-1:0]  circ_b;
  logic signed [odo_pkg::MUL_B_W-1:0]  sin_b;
  logic signed [odo_pkg::MUL_B_W-1:0]  cos_b;

  logic signed [odo_pkg::TRAVEL_W-1:0] travel;
  logic signed [odo_pkg::TRAVEL_W-1:0] last_sel;
  logic signed [odo_pkg::TRAVEL_W:0]   travel_diff;
  logic signed [odo_pkg::TRAVEL_W+1:0] dsum;
  logic signed [odo_pkg::TRAVEL_W:0]   dhalf;
  logic signed [odo_pkg::STEP_W-1:0]   step_sat;
  logic signed [odo_pkg::ACC_W-1:0]    acc_sum;
  logic signed [odo_pkg::INC_W-1:0]    inc;
  logic signed [odo_pkg::POSE_W-1:0]   pose_sel;
  logic signed [odo_pkg::POSE_W:0]     pose_sum;
  logic signed [odo_pkg::POSE_W-1:0]   pose_sat;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  odo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .heading (in_ch.heading),
    .trig    (trig)
  );

  odo_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // The 40-bit step is multiplied in two halves: an unsigned low part and a
  // signed high part, recombined in the accumulator.
  assign step_lo_a = odo_pkg::MUL_A_W'($signed({1'b0, step_r[odo_pkg::LO_W-1:0]}));
  assign step_hi_a = odo_pkg::MUL_A_W'($signed(step_r[odo_pkg::STEP_W-1:odo_pkg::LO_W]));
  assign circ_b    = odo_pkg::MUL_B_W'($signed({1'b0, circ_r}));
  assign sin_b     = odo_pkg::MUL_B_W'(trig.sin_v);
  assign cos_b     = odo_pkg::MUL_B_W'(trig.cos_v);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MR: begin
        mul_a = odo_pkg::MUL_A_W'(rr_r);
        mul_b = circ_b;
      end
      S_ML: begin
        // The left wheel is mirrored, so its position is negated before scaling.
        mul_a = -(odo_pkg::MUL_A_W'(lr_r));
        mul_b = circ_b;
      end
      S_XL: begin
        mul_a = step_lo_a;
        mul_b = sin_b;
      end
      S_XH: begin
        mul_a = step_hi_a;
        mul_b = sin_b;
      end
      S_YL: begin
        mul_a = step_lo_a;
        mul_b = cos_b;
      end
      S_YH: begin
        mul_a = step_hi_a;
        mul_b = cos_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    travel      = prod_r[odo_pkg::TRAVEL_W+odo_pkg::CIRC_FRAC-1:odo_pkg::CIRC_FRAC];
    last_sel    = (state_r == S_ML) ? last_rt_r : last_lt_r;
    travel_diff = (odo_pkg::TRAVEL_W+1)'(travel) - (odo_pkg::TRAVEL_W+1)'(last_sel);

    dsum  = (odo_pkg::TRAVEL_W+2)'(dr_r) + (odo_pkg::TRAVEL_W+2)'(dl_r);
    dhalf = dsum[odo_pkg::TRAVEL_W+1:1];
    if (dhalf[odo_pkg::TRAVEL_W] != dhalf[odo_pkg::TRAVEL_W-1]) begin
      step_sat = dhalf[odo_pkg::TRAVEL_W] ? odo_pkg::STEP_MIN : odo_pkg::STEP_MAX;
    end else begin
      step_sat = dhalf[odo_pkg::STEP_W-1:0];
    end

    acc_sum = acc_r + (odo_pkg::ACC_W'(prod_r) <<< odo_pkg::LO_W);

    inc      = acc_r[odo_pkg::ACC_W-1:odo_pkg::TRIG_FRAC];
    pose_sel = (state_r == S_YH) ? pose_x_r : pose_y_r;
    pose_sum = (odo_pkg::POSE_W+1)'(pose_sel) + (odo_pkg::POSE_W+1)'(inc);
    if (pose_sum[odo_pkg::POSE_W] != pose_sum[odo_pkg::POSE_W-1]) begin
      pose_sat = pose_sum[odo_pkg::POSE_W] ? odo_pkg::POSE_MIN : odo_pkg::POSE_MAX;
    end else begin
      pose_sat = pose_sum[odo_pkg::POSE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MR;
      S_MR:   state_nxt = S_ML;
      S_ML:   state_nxt = S_LT;
      S_LT:   state_nxt = S_STEP;
      S_STEP: state_nxt = S_CORD;
      S_CORD: if (trig.valid) state_nxt = S_XL;
      S_XL:   state_nxt = S_XH;
      S_XH:   state_nxt = S_YL;
      S_YL:   state_nxt = S_YH;
      S_YH:   state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      circ_r      <= odo_pkg::CIRC_RESET;
      last_rt_r   <= '0;
      last_lt_r   <= '0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        circ_r <= cfg_wdata;
      end
      if (state_r == S_YH) begin
        pose_x_r <= pose_sat;
      end
      // The pose y update and the travel hand-over happen together at the end.
      if (out_load) begin
        pose_y_r  <= pose_sat;
        last_rt_r <= rt_r;
        last_lt_r <= lt_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rr_r <= in_ch.right_rotations;
      lr_r <= in_ch.left_rotations;
    end
    if (state_r == S_ML) begin
      rt_r <= travel;
      dr_r <= travel_diff;
    end
    if (state_r == S_LT) begin
      lt_r <= travel;
      dl_r <= travel_diff;
    end
    if (state_r == S_STEP) begin
      step_r <= step_sat;
    end
    if ((state_r == S_XH) || (state_r == S_YH)) begin
      acc_r <= odo_pkg::ACC_W'(prod_r);
    end else if ((state_r == S_YL) || (state_r == S_FIN)) begin
      acc_r <= acc_sum;
    end
    if (out_load) begin
      out_x_r    <= pose_x_r;
      out_y_r    <= pose_sat;
      out_step_r <= step_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.x_position    = out_x_r;
  assign out_ch.y_position    = out_y_r;
  assign out_ch.step_distance = out_step_r;

  `ODO_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready, "request accepted while busy")
  `ODO_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result raised outside the done step")
  `ODO_ASSERT(a_trig_before_products, (state_r == S_XL) |-> trig.valid, "pose products started before trig")

endmodule

`default_nettype wire
